@@ hw/rtl/max_free_rectangle_perimeter_defines.svh @@
// assertion macros for the free rectangle search block
`ifndef MAX_FREE_RECTANGLE_PERIMETER_DEFINES_SVH
`define MAX_FREE_RECTANGLE_PERIMETER_DEFINES_SVH

// same-cycle implication, reset masked
`define MFRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfrp check failed");

// next-cycle implication, reset masked
`define MFRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfrp check failed");

`endif

@@ hw/rtl/mfrp_pkg.sv @@
// shared types and constants of the free rectangle search block
package mfrp_pkg;

  localparam int unsigned DEF_MAX_ROWS = 128;
  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned CfgW         = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned ResultW      = 9;
  localparam int unsigned ResultMax    = 511;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RUN_RD,
    S_RUN_WR,
    S_SRCH_RD,
    S_SRCH_EV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic run_init;
    logic run_rd;
    logic run_wr;
    logic srch_init;
    logic srch_rd;
    logic srch_acc;
    logic srch_next;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic run_col0;
    logic run_row_last;
    logic run_zero;
    logic h_last;
    logic corner_last;
  } status_t;

endpackage

@@ hw/rtl/mfrp_ctrl.sv @@
// controller state machine of the free rectangle search block
module mfrp_ctrl
  import mfrp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    result_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (start_i && status_i.last_cell) begin
          state_d = S_RUN_RD;
        end
      end
      S_RUN_RD: begin
        state_d = S_RUN_WR;
      end
      S_RUN_WR: begin
        if (status_i.run_col0 && status_i.run_row_last) begin
          state_d = S_SRCH_RD;
        end else begin
          state_d = S_RUN_RD;
        end
      end
      S_SRCH_RD: begin
        state_d = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        if ((status_i.run_zero || status_i.h_last) && status_i.corner_last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_DONE: begin
        state_d = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        busy_o         = 1'b0;
        cmd_o.load     = start_i;
        cmd_o.run_init = start_i && status_i.last_cell;
      end
      S_RUN_RD: begin
        cmd_o.run_rd = 1'b1;
      end
      S_RUN_WR: begin
        cmd_o.run_wr    = 1'b1;
        cmd_o.srch_init = status_i.run_col0 && status_i.run_row_last;
      end
      S_SRCH_RD: begin
        cmd_o.srch_rd = 1'b1;
      end
      S_SRCH_EV: begin
        cmd_o.srch_acc  = !status_i.run_zero;
        cmd_o.srch_next = status_i.run_zero || status_i.h_last;
      end
      S_DONE: begin
        result_valid_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/mfrp_datapath.sv @@
// grid and run-length memories, counters and best perimeter of the search
module mfrp_datapath
  import mfrp_pkg::*;
#(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cell_blocked_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic [ResultW-1:0] result_o
);

  localparam int unsigned RowW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowCntW = $clog2(MAX_ROWS + 1);
  localparam int unsigned ColCntW = $clog2(MAX_COLS + 1);
  localparam int unsigned SumW    = $clog2(MAX_ROWS + MAX_COLS + 1);
  localparam int unsigned BestW   = SumW + 1;
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned Depth   = MAX_ROWS * (2 ** ColW);

  logic [CfgW-1:0]    rows_cfg_q, cols_cfg_q;
  logic [RowCntW-1:0] rows_eff;
  logic [ColCntW-1:0] cols_eff;
  logic [31:0]        rows_raw, cols_raw;

  logic [RowW-1:0]    load_row_q, i_row_q, h_row_q;
  logic [ColW-1:0]    load_col_q, i_col_q;
  logic [ColCntW-1:0] run_acc_q, width_q;
  logic [RowCntW-1:0] hgt_q;
  logic [BestW-1:0]   best_q;

  logic               grid_mem [Depth];
  logic [ColCntW-1:0] fr_mem   [Depth];
  logic               grid_rd_q;
  logic [ColCntW-1:0] fr_rd_q;

  logic [AddrW-1:0]   load_addr, run_addr, srch_addr;
  logic               load_col_last, load_row_last, i_col_last, i_row_last;
  logic [ColCntW-1:0] run_new, w_new, width_next;
  logic [SumW-1:0]    sum;
  logic [BestW-1:0]   cand;
  logic [ColW-1:0]    col_next;
  logic [RowW-1:0]    row_next;
  logic [31:0]        best_ext;

  // clamp configured counts into the supported range
  assign rows_raw = 32'(rows_cfg_q);
  assign cols_raw = 32'(cols_cfg_q);
  assign rows_eff = (rows_cfg_q == '0) ? RowCntW'(1) :
                    (rows_raw > MAX_ROWS) ? RowCntW'(MAX_ROWS) : rows_raw[RowCntW-1:0];
  assign cols_eff = (cols_cfg_q == '0) ? ColCntW'(1) :
                    (cols_raw > MAX_COLS) ? ColCntW'(MAX_COLS) : cols_raw[ColCntW-1:0];

  assign load_col_last = (32'(load_col_q) + 32'd1) == 32'(cols_eff);
  assign load_row_last = (32'(load_row_q) + 32'd1) == 32'(rows_eff);
  assign i_col_last    = (32'(i_col_q) + 32'd1) == 32'(cols_eff);
  assign i_row_last    = (32'(i_row_q) + 32'd1) == 32'(rows_eff);

  assign load_addr = {load_row_q, load_col_q};
  assign run_addr  = {i_row_q, i_col_q};
  assign srch_addr = {h_row_q, i_col_q};

  assign status_o.last_cell    = load_col_last && load_row_last;
  assign status_o.run_col0     = (i_col_q == '0);
  assign status_o.run_row_last = i_row_last;
  assign status_o.run_zero     = (fr_rd_q == '0);
  assign status_o.h_last       = (32'(h_row_q) + 32'd1) == 32'(rows_eff);
  assign status_o.corner_last  = i_row_last && i_col_last;

  assign run_new = grid_rd_q ? '0 : run_acc_q + ColCntW'(1);
  assign w_new   = (fr_rd_q < width_q) ? fr_rd_q : width_q;
  assign sum     = SumW'(hgt_q) + SumW'(w_new);
  assign cand    = {sum, 1'b0} - BestW'(1);

  // next corner in row-major order
  assign col_next   = i_col_last ? '0 : i_col_q + ColW'(1);
  assign row_next   = i_col_last ? i_row_q + RowW'(1) : i_row_q;
  assign width_next = cols_eff - ColCntW'(col_next);

  assign best_ext = 32'(best_q);
  assign result_o = (best_ext > ResultMax) ? ResultW'(ResultMax) : best_ext[ResultW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CfgW'(1);
      cols_cfg_q <= CfgW'(1);
      load_row_q <= '0;
      load_col_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_COUNT: begin
          rows_cfg_q <= cfg_data_i;
          load_row_q <= '0;
          load_col_q <= '0;
        end
        REG_COL_COUNT: begin
          cols_cfg_q <= cfg_data_i;
          load_row_q <= '0;
          load_col_q <= '0;
        end
        default: begin
          rows_cfg_q <= rows_cfg_q;
        end
      endcase
    end else if (cmd_i.load) begin
      if (load_col_last) begin
        load_col_q <= '0;
        load_row_q <= load_row_last ? '0 : load_row_q + RowW'(1);
      end else begin
        load_col_q <= load_col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_row_q   <= '0;
      i_col_q   <= '0;
      h_row_q   <= '0;
      run_acc_q <= '0;
      width_q   <= '0;
      hgt_q     <= '0;
      best_q    <= '0;
    end else if (cmd_i.run_init) begin
      i_row_q   <= '0;
      i_col_q   <= ColW'(cols_eff - ColCntW'(1));
      run_acc_q <= '0;
    end else if (cmd_i.run_wr) begin
      if (i_col_q == '0) begin
        i_col_q   <= ColW'(cols_eff - ColCntW'(1));
        i_row_q   <= i_row_q + RowW'(1);
        run_acc_q <= '0;
      end else begin
        i_col_q   <= i_col_q - ColW'(1);
        run_acc_q <= run_new;
      end
      if (cmd_i.srch_init) begin
        i_row_q <= '0;
        i_col_q <= '0;
        h_row_q <= '0;
        hgt_q   <= RowCntW'(1);
        width_q <= cols_eff;
        best_q  <= '0;
      end
    end else begin
      if (cmd_i.srch_acc) begin
        if (cand > best_q) begin
          best_q <= cand;
        end
        width_q <= w_new;
        hgt_q   <= hgt_q + RowCntW'(1);
        h_row_q <= h_row_q + RowW'(1);
      end
      if (cmd_i.srch_next) begin
        i_col_q <= col_next;
        i_row_q <= row_next;
        h_row_q <= row_next;
        hgt_q   <= RowCntW'(1);
        width_q <= width_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      grid_mem[load_addr] <= cell_blocked_i;
    end
    if (cmd_i.run_rd) begin
      grid_rd_q <= grid_mem[run_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_wr) begin
      fr_mem[run_addr] <= run_new;
    end
    if (cmd_i.srch_rd) begin
      fr_rd_q <= fr_mem[srch_addr];
    end
  end

endmodule

@@ hw/rtl/max_free_rectangle_perimeter.sv @@
// top level of the free rectangle search block
// Cells are loaded one per cycle in row-major order while busy is low; the
// transfer of the last cell of the configured grid starts the search and busy
// goes high. The search first builds a run-length table, reading and then
// writing each cell, then visits every top-left corner and walks downward one
// row at a time, reading each run length through the single read port of the
// run-length memory and then evaluating it. The result is shown for one cycle
// with result_valid_o and cannot be stalled; busy falls in the next cycle. The
// grid memory needs no clearing after reset.
module max_free_rectangle_perimeter
  import mfrp_pkg::*;
#(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cell_blocked_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output logic               result_valid_o,
  output logic [ResultW-1:0] best_perimeter_less_one_o
);

  cmd_t    cmd;
  status_t status;

  mfrp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  mfrp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cell_blocked_i (cell_blocked_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (best_perimeter_less_one_o)
  );

endmodule

@@ hw/rtl/mfrp_checker.sv @@
// port-level checks of the free rectangle search block and their binding
`include "max_free_rectangle_perimeter_defines.svh"

module mfrp_checker
  import mfrp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               cell_blocked_i,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [CfgW-1:0]    cfg_data_i,
  input logic               result_valid_o,
  input logic [ResultW-1:0] best_perimeter_less_one_o
);

  // one result per search
  `MFRP_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o)
  // the result comes at the end of a busy period
  `MFRP_ASSERT_NOW(a_strobe_busy, result_valid_o, busy)
  `MFRP_ASSERT_NEXT(a_idle_after_result, result_valid_o, !busy)
  // busy only drops after a result transfer
  `MFRP_ASSERT_NOW(a_release_after_result, $fell(busy), $past(result_valid_o))

endmodule

bind max_free_rectangle_perimeter mfrp_checker u_mfrp_checker (.*);
